[rtl/core/index_set_claim_table_top_macros.svh]
// ----------------------------------------------------------------------------
// index_set_claim_table_top_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INDEX_SET_CLAIM_TABLE_TOP_MACROS_SVH
`define INDEX_SET_CLAIM_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define IST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, disabled in reset
`define IST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[rtl/core/ist_pkg.sv]
// ----------------------------------------------------------------------------
// ist_pkg
// Shared constants and store access types of the index set claim table.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

    localparam int CAPACITY     = 256;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int WORD_W       = $clog2(CAPACITY + 1);
    localparam int CFG_W        = 9;
    localparam int IDX_W        = 16;
    localparam int KIND_W       = 2;
    localparam int STAT_W       = 3;
    localparam int ORD_W        = 8;
    localparam int OUT_TDATA_W  = 16;
    localparam int ACTIVE_RESET = 256;

    localparam logic [KIND_W-1:0] KIND_CLAIM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_SCHEMA    = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] cw_raddr;
        logic              cw_we;
        logic [ADDR_W-1:0] cw_waddr;
        logic [WORD_W-1:0] cw_wdata;
        logic [ADDR_W-1:0] mb_raddr;
        logic              mb_we;
        logic [ADDR_W-1:0] mb_waddr;
        logic [ADDR_W-1:0] mb_wdata;
        logic [ADDR_W-1:0] v_raddr;
        logic              v_we;
        logic [ADDR_W-1:0] v_waddr;
        logic              v_wdata;
    } t_store_req;

    typedef struct packed {
        logic [WORD_W-1:0] cw_rdata;
        logic [ADDR_W-1:0] mb_rdata;
        logic              v_rdata;
    } t_store_rsp;

endpackage

`default_nettype wire

[rtl/core/ist_store.sv]
// ----------------------------------------------------------------------------
// ist_store
// Claim word memory, set member memory and per-entry occupied bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_store
    import ist_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_req i_req,
    output t_store_rsp      o_rsp
);

    logic [WORD_W-1:0]   r_cw_mem [CAPACITY];
    logic [ADDR_W-1:0]   r_mb_mem [CAPACITY];
    logic [WORD_W-1:0]   r_cw_rdata;
    logic [ADDR_W-1:0]   r_mb_rdata;
    logic [CAPACITY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.cw_we) begin
            r_cw_mem[i_req.cw_waddr] <= i_req.cw_wdata;
        end
        r_cw_rdata <= r_cw_mem[i_req.cw_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mb_we) begin
            r_mb_mem[i_req.mb_waddr] <= i_req.mb_wdata;
        end
        r_mb_rdata <= r_mb_mem[i_req.mb_raddr];
    end

    // entry not marked reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.v_we) begin
            r_vld[i_req.v_waddr] <= i_req.v_wdata;
        end
    end

    assign o_rsp.cw_rdata = r_cw_rdata;
    assign o_rsp.mb_rdata = r_mb_rdata;
    assign o_rsp.v_rdata  = r_vld[i_req.v_raddr];

endmodule

`default_nettype wire

[rtl/core/ist_ctrl.sv]
// ----------------------------------------------------------------------------
// ist_ctrl
// Item sequencer: lookup, duplicate check, rollback walk and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_ctrl
    import ist_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IDX_W-1:0]       s_axis_tdata,   // [15:0] index
    input  wire logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    input  wire logic                   s_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [2:0] status, [10:3] ordinal
    output logic                        m_axis_tlast,
    output t_store_req                  o_req,
    input  wire t_store_rsp             i_rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_DUP  = 4'b0100,
        S_RB   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_last, n_last;
    logic [WORD_W-1:0]  r_len, n_len;
    logic               r_failed, n_failed;
    logic [STAT_W-1:0]  r_sstat, n_sstat;
    logic [STAT_W-1:0]  r_code, n_code;
    logic [WORD_W-1:0]  r_ptr, n_ptr;
    logic               r_rb_pend, n_rb_pend;
    logic [CFG_W-1:0]   r_active;
    logic               r_res_pend, n_res_pend;
    logic [STAT_W-1:0]  r_res_stat, n_res_stat;
    logic [ORD_W-1:0]   r_res_ord, n_res_ord;
    logic               r_res_done, n_res_done;
    logic               r_ov, n_ov;
    logic [STAT_W-1:0]  r_ostat, n_ostat;
    logic [ORD_W-1:0]   r_oord, n_oord;
    logic               r_odone, n_odone;

    logic               out_free;
    logic               in_acc;
    logic [IDX_W-1:0]   active16;
    logic [IDX_W-1:0]   range16;
    logic               idx_in;
    logic [WORD_W-1:0]  word;

    assign out_free      = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_res_pend || out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign active16 = IDX_W'(r_active);
    assign range16  = (active16 < IDX_W'(CAPACITY)) ? active16 : IDX_W'(CAPACITY);
    assign idx_in   = r_idx < range16;
    assign word     = i_rsp.cw_rdata;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {(OUT_TDATA_W - ORD_W - STAT_W)'(0), r_oord, r_ostat};
    assign m_axis_tlast  = r_odone;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_idx      = r_idx;
        n_last     = r_last;
        n_len      = r_len;
        n_failed   = r_failed;
        n_sstat    = r_sstat;
        n_code     = r_code;
        n_ptr      = r_ptr;
        n_rb_pend  = r_rb_pend;
        n_res_pend = r_res_pend;
        n_res_stat = r_res_stat;
        n_res_ord  = r_res_ord;
        n_res_done = r_res_done;
        n_ov       = r_ov;
        n_ostat    = r_ostat;
        n_oord     = r_oord;
        n_odone    = r_odone;

        o_req          = '0;
        o_req.cw_raddr = s_axis_tdata[ADDR_W-1:0];
        o_req.v_raddr  = r_idx[ADDR_W-1:0];
        o_req.mb_raddr = r_ptr[ADDR_W-1:0];

        // output register
        if (out_free) begin
            n_ov       = r_res_pend;
            n_res_pend = 1'b0;
            if (r_res_pend) begin
                n_ostat = r_res_stat;
                n_oord  = r_res_ord;
                n_odone = r_res_done;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind  = s_axis_tuser;
                    n_idx   = s_axis_tdata;
                    n_last  = s_axis_tlast;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res_ord  = '0;
                n_res_done = 1'b0;
                case (r_kind)
                    KIND_CLAIM: begin
                        if (r_failed) begin
                            n_res_pend = 1'b1;
                            n_res_stat = r_sstat;
                            n_res_done = r_last;
                            if (r_last) begin
                                n_len    = '0;
                                n_failed = 1'b0;
                                n_sstat  = ST_OK;
                            end
                            n_state = S_IDLE;
                        end else if (!idx_in || IDX_W'(r_len) >= range16) begin
                            n_code    = ST_INVALID;
                            n_ptr     = '0;
                            n_rb_pend = 1'b0;
                            n_state   = S_RB;
                        end else if (i_rsp.v_rdata) begin
                            if (IDX_W'(word) <= IDX_W'(r_len)) begin
                                o_req.mb_raddr = ADDR_W'(word - WORD_W'(1));
                                n_state        = S_DUP;
                            end else begin
                                n_code    = ST_BUSY;
                                n_ptr     = '0;
                                n_rb_pend = 1'b0;
                                n_state   = S_RB;
                            end
                        end else begin
                            o_req.cw_we    = 1'b1;
                            o_req.cw_waddr = r_idx[ADDR_W-1:0];
                            o_req.cw_wdata = r_len + WORD_W'(1);
                            o_req.v_we     = 1'b1;
                            o_req.v_waddr  = r_idx[ADDR_W-1:0];
                            o_req.v_wdata  = 1'b1;
                            o_req.mb_we    = 1'b1;
                            o_req.mb_waddr = r_len[ADDR_W-1:0];
                            o_req.mb_wdata = r_idx[ADDR_W-1:0];
                            n_len          = r_last ? '0 : r_len + WORD_W'(1);
                            n_res_pend     = 1'b1;
                            n_res_stat     = ST_OK;
                            n_res_done     = r_last;
                            n_state        = S_IDLE;
                        end
                    end
                    KIND_RELEASE: begin
                        if (idx_in) begin
                            o_req.v_we    = 1'b1;
                            o_req.v_waddr = r_idx[ADDR_W-1:0];
                            o_req.v_wdata = 1'b0;
                        end
                        n_res_pend = 1'b1;
                        n_res_stat = ST_OK;
                        n_state    = S_IDLE;
                    end
                    KIND_QUERY: begin
                        n_res_pend = 1'b1;
                        if (!idx_in) begin
                            n_res_stat = ST_INVALID;
                        end else if (!i_rsp.v_rdata) begin
                            n_res_stat = ST_NOT_FOUND;
                        end else if (IDX_W'(word) > range16) begin
                            n_res_stat = ST_SCHEMA;
                        end else begin
                            n_res_stat = ST_OK;
                            n_res_ord  = ORD_W'(word - WORD_W'(1));
                        end
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_res_pend = 1'b1;
                        n_res_stat = ST_INVALID;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_DUP: begin
                n_code    = (i_rsp.mb_rdata == r_idx[ADDR_W-1:0]) ? ST_INVALID : ST_BUSY;
                n_ptr     = '0;
                n_rb_pend = 1'b0;
                n_state   = S_RB;
            end
            S_RB: begin
                // walk members, freeing those still in range
                if (r_ptr < r_len) begin
                    n_ptr     = r_ptr + WORD_W'(1);
                    n_rb_pend = 1'b1;
                end else begin
                    n_rb_pend = 1'b0;
                end
                if (r_rb_pend && (IDX_W'(i_rsp.mb_rdata) < range16)) begin
                    o_req.v_we    = 1'b1;
                    o_req.v_waddr = i_rsp.mb_rdata;
                    o_req.v_wdata = 1'b0;
                end
                if ((r_ptr == r_len) && !r_rb_pend) begin
                    n_res_pend = 1'b1;
                    n_res_stat = r_code;
                    n_res_ord  = '0;
                    n_res_done = r_last;
                    n_len      = '0;
                    n_failed   = !r_last;
                    n_sstat    = r_last ? ST_OK : r_code;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_failed   <= 1'b0;
            r_sstat    <= ST_OK;
            r_rb_pend  <= 1'b0;
            r_res_pend <= 1'b0;
            r_ov       <= 1'b0;
            r_active   <= CFG_W'(ACTIVE_RESET);
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_failed   <= n_failed;
            r_sstat    <= n_sstat;
            r_rb_pend  <= n_rb_pend;
            r_res_pend <= n_res_pend;
            r_ov       <= n_ov;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_code     <= n_code;
        r_ptr      <= n_ptr;
        r_res_stat <= n_res_stat;
        r_res_ord  <= n_res_ord;
        r_res_done <= n_res_done;
        r_ostat    <= n_ostat;
        r_oord     <= n_oord;
        r_odone    <= n_odone;
    end

endmodule

`default_nettype wire

[rtl/core/index_set_claim_table_top.sv]
// Release, query and successful or skipped claim elements are captured in
// S_IDLE, handled in S_LOOK and written to the result register.
// A failing claim walks the set member memory in S_RB, one member per cycle,
// after the member check in S_DUP when that runs. Items are taken only in S_IDLE.
// Reset (synchronous, active low) frees every entry at once, clears the set in
// progress and sets active_entries to 256; no clearing pass.
// ----------------------------------------------------------------------------
// index_set_claim_table_top
// Table of claim words with all-or-nothing set claims, releases and queries.
// ----------------------------------------------------------------------------
`default_nettype none

module index_set_claim_table_top
    import ist_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IDX_W-1:0]       s_axis_tdata,   // [15:0] index
    input  wire logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    input  wire logic                   s_axis_tlast,   // last_in_set
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_W-1:0]       i_cfg_data,     // [8:0] active_entries
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [2:0] status, [10:3] ordinal
    output logic                        m_axis_tlast    // set_done
);

    t_store_req req;
    t_store_rsp rsp;

    ist_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_req         (req),
        .i_rsp         (rsp)
    );

    ist_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

endmodule

`default_nettype wire

[rtl/core/ist_checker.sv]
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks on the result stream of the claim table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "index_set_claim_table_top_macros.svh"

module ist_checker
    import ist_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    logic [STAT_W-1:0] stat;
    logic [ORD_W-1:0]  ord;
    logic              pad_zero;

    assign stat     = m_axis_tdata[STAT_W-1:0];
    assign ord      = m_axis_tdata[STAT_W+ORD_W-1:STAT_W];
    assign pad_zero = (m_axis_tdata[OUT_TDATA_W-1:STAT_W+ORD_W] == '0);

    `IST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `IST_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_axis_tvalid,
        stat <= ST_SCHEMA && pad_zero)
    `IST_ASSERT_NOW(a_ord_only_ok, i_clk, i_rst_n, m_axis_tvalid && stat != ST_OK,
        ord == '0)
    `IST_ASSERT_NOW(a_done_no_ord, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
        ord == '0 && stat != ST_NOT_FOUND && stat != ST_SCHEMA)

endmodule

bind index_set_claim_table_top ist_checker u_ist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the index set claim table. A short directed table
// covers range edges, busy and repeated members, rollback, ignored elements,
// schema errors and range changes in the middle of a set. Random phases follow
// under several range settings. Directed rows marked typed are checked against
// their table entry, others against an in-bench model of the claim table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import ist_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int N_DIR = 30;
    localparam int N_PHASE = 12;
    localparam int PHASE_ITEMS = 94;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ORD_W-1:0]  ordinal;
        logic              set_done;
    } t_claim_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op           op;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [CFG_W-1:0]  cfg;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [ORD_W-1:0]  ordinal;
        logic              set_done;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IDX_W-1:0]       s_axis_tdata;    // [15:0] index
    logic [KIND_W-1:0]      s_axis_tuser;    // [1:0] kind
    logic                   s_axis_tlast;    // last_in_set
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;      // [8:0] active_entries
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [2:0] status, [10:3] ordinal
    logic                   m_axis_tlast;    // set_done

    index_set_claim_table_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // model of the claim table
    logic [WORD_W-1:0] model_word [CAPACITY] = '{default: '0};
    logic [ADDR_W-1:0] model_members [CAPACITY] = '{default: '0};
    int                model_set_len = 0;
    logic              model_set_failed = 1'b0;
    logic [STAT_W-1:0] model_set_status = ST_OK;
    logic [CFG_W-1:0]  model_active = CFG_W'(ACTIVE_RESET);

    t_claim_res pending_results [$];
    int         mismatch_count = 0;
    int         sent_items = 0;

    logic       typed_on;
    t_claim_res typed_res;

    int stall_pct;
    int gap_pct;
    int hold_req = 0;

    t_dir_row         dir_tab [N_DIR];
    logic [CFG_W-1:0] phase_range [N_PHASE];

    function automatic int range_now();
        return (model_active < CAPACITY) ? int'(model_active) : CAPACITY;
    endfunction

    function automatic t_claim_res predict_claim_result(logic [KIND_W-1:0] kind,
                                                        logic [IDX_W-1:0] idx,
                                                        logic last);
        t_claim_res        r;
        int                rng;
        int                i;
        logic [STAT_W-1:0] code;
        rng = range_now();
        r = '{ST_OK, '0, 1'b0};
        case (kind)
            KIND_CLAIM: begin
                if (!model_set_failed) begin
                    code = ST_OK;
                    if (int'(idx) >= rng || model_set_len >= rng) begin
                        code = ST_INVALID;
                    end else if (model_word[idx[ADDR_W-1:0]] != 0) begin
                        code = ST_BUSY;
                        for (i = 0; i < model_set_len; i++)
                            if (model_members[i] == idx[ADDR_W-1:0])
                                code = ST_INVALID;
                    end else begin
                        model_word[idx[ADDR_W-1:0]] = WORD_W'(model_set_len + 1);
                        model_members[model_set_len] = idx[ADDR_W-1:0];
                        model_set_len++;
                    end
                    if (code != ST_OK) begin
                        // rollback only touches members still in range
                        for (i = 0; i < model_set_len; i++)
                            if (int'(model_members[i]) < rng)
                                model_word[model_members[i]] = '0;
                        model_set_len = 0;
                        model_set_failed = 1'b1;
                        model_set_status = code;
                    end
                end
                r.status = model_set_status;
                if (last) begin
                    r.set_done = 1'b1;
                    model_set_len = 0;
                    model_set_failed = 1'b0;
                    model_set_status = ST_OK;
                end
            end
            KIND_RELEASE: begin
                if (int'(idx) < rng)
                    model_word[idx[ADDR_W-1:0]] = '0;
            end
            KIND_QUERY: begin
                if (int'(idx) >= rng)
                    r.status = ST_INVALID;
                else if (model_word[idx[ADDR_W-1:0]] == 0)
                    r.status = ST_NOT_FOUND;
                else if (int'(model_word[idx[ADDR_W-1:0]]) > rng)
                    r.status = ST_SCHEMA;
                else
                    r.ordinal = ORD_W'(model_word[idx[ADDR_W-1:0]] - 1);
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    // scoreboard: check results first, then log newly accepted items
    always @(posedge i_clk) begin
        t_claim_res got;
        t_claim_res exp_res;
        t_claim_res pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast};
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d ordinal %0d set_done %0d",
                           got.status, got.ordinal, got.set_done);
                    mismatch_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (got.status != exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, got.status);
                        mismatch_count++;
                    end
                    if (got.ordinal != exp_res.ordinal) begin
                        $error("ordinal: expected %0d, got %0d",
                               exp_res.ordinal, got.ordinal);
                        mismatch_count++;
                    end
                    if (got.set_done != exp_res.set_done) begin
                        $error("set_done: expected %0d, got %0d",
                               exp_res.set_done, got.set_done);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_claim_result(s_axis_tuser, s_axis_tdata, s_axis_tlast);
                pending_results.push_back(typed_on ? typed_res : pred);
                sent_items++;
            end
            if (i_cfg_valid && o_cfg_ready)
                model_active = i_cfg_data;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stalls, bursts and a requested long hold-off
    initial begin
        int hold_left;
        int burst_left;
        int hold_seen;
        hold_left = 0;
        burst_left = 0;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_axis_tready = 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_axis_tready = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(8, 40);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        return ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    endfunction

    function automatic logic [IDX_W-1:0] pick_entry(logic want_taken);
        int               rng;
        int               k;
        logic [IDX_W-1:0] c;
        rng = range_now();
        if (rng == 0)
            return IDX_W'($urandom);
        for (k = 0; k < 12; k++) begin
            c = IDX_W'($urandom_range(0, rng - 1));
            if ((model_word[c[ADDR_W-1:0]] != 0) == want_taken)
                return c;
        end
        return IDX_W'($urandom_range(0, rng - 1));
    endfunction

    function automatic logic [IDX_W-1:0] pick_outside();
        return IDX_W'($urandom_range(range_now(), 65535));
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic last, input logic typed, input t_claim_res t);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = idx;
        s_axis_tlast = last;
        typed_on = typed;
        typed_res = t;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic go_quiet_and_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // a failing claim may still be walking its members
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_range(input logic [CFG_W-1:0] value);
        go_quiet_and_drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_other();
        int               r;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            kind = KIND_RELEASE;
            idx = pick_entry(1'b1);
        end else if (r < 52) begin
            kind = KIND_RELEASE;
            idx = ($urandom_range(0, 1) != 0) ? pick_outside() : IDX_W'($urandom);
        end else if (r < 72) begin
            kind = KIND_QUERY;
            idx = pick_entry(1'b1);
        end else if (r < 82) begin
            kind = KIND_QUERY;
            idx = pick_entry(1'b0);
        end else if (r < 93) begin
            kind = KIND_QUERY;
            idx = ($urandom_range(0, 1) != 0) ? pick_outside() : IDX_W'($urandom);
        end else begin
            kind = KIND_UNUSED;
            idx = IDX_W'($urandom);
        end
        send_item(kind, idx, 1'($urandom), 1'b0, '0);
    endtask

    task automatic run_set();
        int               len;
        int               k;
        int               r;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] used [$];
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 6)
                send_other();
            r = $urandom_range(0, 99);
            if (r < 76)
                idx = pick_entry(1'b0);
            else if (r < 86)
                idx = pick_entry(1'b1);
            else if (r < 92 && k > 0)
                idx = used[$urandom_range(0, used.size() - 1)];
            else if (r < 97)
                idx = pick_outside();
            else
                idx = IDX_W'($urandom);
            used.push_back(idx);
            send_item(KIND_CLAIM, idx, k == len - 1, 1'b0, '0);
        end
    endtask

    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int i;
        int ph;
        int goal;
        int saved_gap;
        t_dir_row row;

        typed_on = 1'b0;
        typed_res = '0;
        stall_pct = 20;
        gap_pct = 20;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_CLAIM;
        s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;

        dir_tab = '{
            '{ROW_ITEM, KIND_QUERY,   16'd0,      1'b0, 9'd0,   1'b1, ST_NOT_FOUND, 8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd255,    1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd0,      1'b1, 9'd0,   1'b1, ST_OK,        8'd0, 1'b1},
            '{ROW_ITEM, KIND_QUERY,   16'd255,    1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'd0,      1'b0, 9'd0,   1'b1, ST_OK,        8'd1, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'hFFFF,   1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd256,    1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b1},
            // taken by another set, then an ignored tail element
            '{ROW_ITEM, KIND_CLAIM,   16'd5,      1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd255,    1'b0, 9'd0,   1'b1, ST_BUSY,      8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd7,      1'b1, 9'd0,   1'b1, ST_BUSY,      8'd0, 1'b1},
            '{ROW_ITEM, KIND_QUERY,   16'd5,      1'b0, 9'd0,   1'b1, ST_NOT_FOUND, 8'd0, 1'b0},
            // index repeated within one set
            '{ROW_ITEM, KIND_CLAIM,   16'd9,      1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd9,      1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b1},
            '{ROW_ITEM, KIND_RELEASE, 16'd255,    1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_RELEASE, 16'hFFFF,   1'b1, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'd255,    1'b0, 9'd0,   1'b1, ST_NOT_FOUND, 8'd0, 1'b0},
            '{ROW_ITEM, KIND_UNUSED,  16'hAAAA,   1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b0},
            // range lowered while a set is open
            '{ROW_ITEM, KIND_CLAIM,   16'd3,      1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_CFG,  KIND_CLAIM,   16'd0,      1'b0, 9'd2,   1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd1,      1'b0, 9'd0,   1'b1, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd0,      1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b1},
            '{ROW_ITEM, KIND_QUERY,   16'd0,      1'b0, 9'd0,   1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_CFG,  KIND_CLAIM,   16'd0,      1'b0, 9'd1,   1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'd0,      1'b0, 9'd0,   1'b1, ST_SCHEMA,    8'd0, 1'b0},
            '{ROW_CFG,  KIND_CLAIM,   16'd0,      1'b0, 9'd0,   1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_CLAIM,   16'd0,      1'b1, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b1},
            '{ROW_ITEM, KIND_QUERY,   16'd0,      1'b0, 9'd0,   1'b1, ST_INVALID,   8'd0, 1'b0},
            '{ROW_CFG,  KIND_CLAIM,   16'd0,      1'b0, 9'd511, 1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'd3,      1'b0, 9'd0,   1'b0, ST_OK,        8'd0, 1'b0},
            '{ROW_ITEM, KIND_QUERY,   16'd1,      1'b0, 9'd0,   1'b0, ST_OK,        8'd0, 1'b0}
        };
        phase_range = '{9'd256, 9'd16, 9'd40, 9'd1, 9'd8, 9'd511,
                        9'd0, 9'd100, 9'd3, 9'd256, 9'd24, 9'd300};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            row = dir_tab[i];
            if (row.op == ROW_CFG)
                write_range(row.cfg);
            else
                send_item(row.kind, row.idx, row.last, row.typed,
                          '{row.status, row.ordinal, row.set_done});
        end

        for (ph = 0; ph < N_PHASE; ph++) begin
            write_range(phase_range[ph]);
            if (ph % 4 == 3) begin
                stall_pct = 0;
                gap_pct = 0;
            end else begin
                stall_pct = $urandom_range(5, 60);
                gap_pct = $urandom_range(5, 50);
            end
            goal = sent_items + PHASE_ITEMS;
            if (ph == 1 || ph == 6) begin
                // long result hold-off while items keep coming
                saved_gap = gap_pct;
                gap_pct = 0;
                hold_req++;
                repeat (6) run_set();
                gap_pct = saved_gap;
            end
            while (sent_items < goal) begin
                if ($urandom_range(0, 99) < 70)
                    run_set();
                else
                    repeat ($urandom_range(1, 3)) send_other();
            end
        end

        go_quiet_and_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/ist_pkg.sv
rtl/core/ist_store.sv
rtl/core/ist_ctrl.sv
rtl/core/index_set_claim_table_top.sv
rtl/core/ist_checker.sv
dv/tb_top.sv
